[design/clct_pkg.sv]
// ============================================================================
// clct_pkg: shared types and constants for the character LCD cursor terminal
// Holds the item kinds, cursor move codes, the queue entry layout and the
// HD44780 command byte constants that the front, queue and back modules use.
// ============================================================================
`default_nettype none

package clct_pkg;

    // Kinds of input items, as carried on the slave-side tuser.
    typedef enum logic [1:0] {
        K_CHAR   = 2'd0,
        K_MOVE   = 2'd1,
        K_SETPOS = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    // Cursor move directions.
    typedef enum logic [2:0] {
        MV_RIGHT  = 3'd0,
        MV_LEFT   = 3'd1,
        MV_UP     = 3'd2,
        MV_DOWN   = 3'd3,
        MV_END    = 3'd4,
        MV_START  = 3'd5,
        MV_TOP    = 3'd6,
        MV_BOTTOM = 3'd7
    } t_move_dir;

    // One classified operation waiting between the front and the back.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  code;
        t_move_dir   dir;
        logic [5:0]  col;
        logic [2:0]  row;
    } t_op;

    // One byte for the LCD bus with its register select.
    typedef struct packed {
        logic        is_data;
        logic [7:0]  lcd_byte;
    } t_lcd_word;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = 1;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
    localparam logic [7:0] ROW1_BASE     = 8'h40;
    localparam logic [7:0] UNKNOWN_GLYPH = 8'hA5;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;

    // Register index of the extended character switch.
    localparam logic REG_EXT_CHARS = 1'b0;

endpackage

`default_nettype wire

[design/clct_front.sv]
// ============================================================================
// clct_front: input classifier
// Decodes an input item into a queue operation, folds accented letters and
// flags items that produce no LCD bytes so that they can be dropped.
// ============================================================================
`default_nettype none

module clct_front #(
    parameter int ROWS = 2,
    parameter int COLS = 16
) (
    input  wire logic [1:0]       i_kind,
    input  wire logic [7:0]       i_char_code,
    input  wire logic [2:0]       i_move_dir,
    input  wire logic [5:0]       i_col_pos,
    input  wire logic [2:0]       i_row_pos,
    input  wire logic             i_ext_chars,
    output clct_pkg::t_op         o_op,
    output logic                  o_keep
);

    // Unless extended characters are on, Latin-1 accented A (not A-ring), C, E, I, O
    // and U become their plain letter; anything else above ASCII becomes the block glyph.
    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ext);
        logic [7:0] up;
        logic [7:0] letter;
        logic       known;
        begin
            up     = c & 8'hDF;
            letter = 8'h41;
            known  = 1'b1;
            if (up <= 8'hC4) begin
                letter = 8'h41;
            end else if (up == 8'hC7) begin
                letter = 8'h43;
            end else if (up >= 8'hC8 && up <= 8'hCB) begin
                letter = 8'h45;
            end else if (up >= 8'hCC && up <= 8'hCF) begin
                letter = 8'h49;
            end else if (up >= 8'hD2 && up <= 8'hD6) begin
                letter = 8'h4F;
            end else if (up >= 8'hD9 && up <= 8'hDC) begin
                letter = 8'h55;
            end else begin
                known = 1'b0;
            end
            if (ext || c <= 8'h7F) begin
                fold_char = c;
            end else if (c < 8'hC0 || !known) begin
                fold_char = clct_pkg::UNKNOWN_GLYPH;
            end else if (c >= 8'hE0) begin
                fold_char = letter + 8'h20;
            end else begin
                fold_char = letter;
            end
        end
    endfunction

    always_comb begin
        o_op.kind = clct_pkg::t_kind'(i_kind);
        o_op.code = fold_char(i_char_code, i_ext_chars);
        o_op.dir  = clct_pkg::t_move_dir'(i_move_dir);
        o_op.col  = i_col_pos;
        o_op.row  = i_row_pos;
        o_keep    = 1'b1;
        unique case (clct_pkg::t_kind'(i_kind))
            clct_pkg::K_CHAR: begin
                if (i_char_code < clct_pkg::CH_SPACE) begin
                    // Newline acts as a move down, carriage return as a move
                    // to the row start; other control bytes are dropped.
                    o_op.kind = clct_pkg::K_MOVE;
                    if (i_char_code == clct_pkg::CH_NL) begin
                        o_op.dir = clct_pkg::MV_DOWN;
                    end else if (i_char_code == clct_pkg::CH_CR) begin
                        o_op.dir = clct_pkg::MV_START;
                    end else begin
                        o_keep = 1'b0;
                    end
                end
            end
            clct_pkg::K_SETPOS: begin
                o_keep = (int'(i_col_pos) < COLS) && (int'(i_row_pos) < ROWS);
            end
            default: begin
                o_keep = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/clct_queue.sv]
// ============================================================================
// clct_queue: operation queue
// A two-entry register queue that decouples the classifier from the byte
// sequencer so either side can stall without holding up the other.
// ============================================================================
`default_nettype none

module clct_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  clct_pkg::t_op       i_push_op,
    output logic                o_not_full,
    input  wire logic           i_pop,
    output logic                o_not_empty,
    output clct_pkg::t_op       o_head
);

    clct_pkg::t_op                r_mem [clct_pkg::QDEPTH];
    logic [clct_pkg::QAW-1:0]     r_wp;
    logic [clct_pkg::QAW-1:0]     r_rp;
    logic [clct_pkg::QAW:0]       r_cnt;
    logic [clct_pkg::QAW:0]       n_cnt;

    assign o_not_full  = (r_cnt != (clct_pkg::QAW + 1)'(clct_pkg::QDEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_head      = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_not_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (clct_pkg::QAW + 1)'(clct_pkg::QDEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

[design/clct_back.sv]
// ============================================================================
// clct_back: cursor tracker and byte sequencer
// Takes one queued operation at a time, updates the cursor and the pending
// clear flag, and sends the resulting one to three bytes one per cycle while the output is ready.
// ============================================================================
`default_nettype none

module clct_back #(
    parameter int ROWS = 2,
    parameter int COLS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_op_valid,
    input  clct_pkg::t_op       i_op,
    output logic                o_op_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output clct_pkg::t_lcd_word o_word,
    output logic                o_last
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

    function automatic logic [7:0] addr_of(input logic [RW-1:0] row,
                                           input logic [CW-1:0] col);
        logic [7:0] base;
        begin
            base    = (row != '0) ? clct_pkg::ROW1_BASE : 8'h00;
            addr_of = clct_pkg::CMD_SET_ADDR | ((base + 8'(col)) & 8'h7F);
        end
    endfunction

    logic [RW-1:0]        r_row;
    logic [CW-1:0]        r_col;
    logic                 r_clr;
    logic                 r_job_v;
    clct_pkg::t_lcd_word  r_list [3];
    logic [1:0]           r_cnt;
    logic [1:0]           r_pos;
    logic                 r_out_v;
    clct_pkg::t_lcd_word  r_out_word;
    logic                 r_out_last;

    logic [RW-1:0]        n_row;
    logic [CW-1:0]        n_col;
    logic                 n_clr;
    clct_pkg::t_lcd_word  n_list [3];
    logic [1:0]           n_cnt;
    logic [1:0]           k;

    logic adv;
    logic emit;
    logic fin;
    logic load;

    assign adv  = !r_out_v || i_ready;
    assign emit = adv && r_job_v;
    assign fin  = emit && (r_pos == r_cnt - 2'd1);
    assign load = i_op_valid && (!r_job_v || fin);

    assign o_op_pop = load;
    assign o_valid  = r_out_v;
    assign o_word   = r_out_word;
    assign o_last   = r_out_last;

    // Next cursor state and byte list for the operation at the queue head.
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_clr  = r_clr;
        n_list = '{default: '0};
        n_cnt  = 2'd1;
        k      = 2'd0;
        unique case (i_op.kind)
            clct_pkg::K_CHAR: begin
                if (r_clr) begin
                    n_list[0] = '{is_data: 1'b0, lcd_byte: clct_pkg::CMD_CLEAR};
                    n_clr     = 1'b0;
                    k         = 2'd1;
                end
                n_list[k] = '{is_data: 1'b1, lcd_byte: i_op.code};
                if (r_col == LAST_COL) begin
                    n_col = '0;
                    n_row = (r_row == LAST_ROW) ? '0 : RW'(r_row + 1'b1);
                end else begin
                    n_col = CW'(r_col + 1'b1);
                end
                if (n_row != r_row) begin
                    n_list[k + 2'd1] = '{is_data: 1'b0, lcd_byte: addr_of(n_row, n_col)};
                    n_cnt            = k + 2'd2;
                end else begin
                    n_cnt = k + 2'd1;
                end
            end
            clct_pkg::K_MOVE: begin
                unique case (i_op.dir)
                    clct_pkg::MV_RIGHT: begin
                        if (r_col == LAST_COL) begin
                            n_col = '0;
                            n_row = (r_row == LAST_ROW) ? '0 : RW'(r_row + 1'b1);
                        end else begin
                            n_col = CW'(r_col + 1'b1);
                        end
                    end
                    clct_pkg::MV_LEFT: begin
                        if (r_col == '0) begin
                            n_col = LAST_COL;
                            n_row = (r_row == '0) ? LAST_ROW : RW'(r_row - 1'b1);
                        end else begin
                            n_col = CW'(r_col - 1'b1);
                        end
                    end
                    clct_pkg::MV_UP: begin
                        if (r_row == '0) begin
                            n_row = LAST_ROW;
                            n_clr = 1'b1;
                        end else begin
                            n_row = RW'(r_row - 1'b1);
                        end
                    end
                    clct_pkg::MV_DOWN: begin
                        if (r_row == LAST_ROW) begin
                            n_row = '0;
                            n_clr = 1'b1;
                        end else begin
                            n_row = RW'(r_row + 1'b1);
                        end
                    end
                    clct_pkg::MV_END:    n_col = LAST_COL;
                    clct_pkg::MV_START:  n_col = '0;
                    clct_pkg::MV_TOP:    n_row = '0;
                    clct_pkg::MV_BOTTOM: n_row = LAST_ROW;
                    default:             n_row = r_row;
                endcase
                n_list[0] = '{is_data: 1'b0, lcd_byte: addr_of(n_row, n_col)};
            end
            clct_pkg::K_SETPOS: begin
                n_row     = RW'(i_op.row);
                n_col     = CW'(i_op.col);
                n_list[0] = '{is_data: 1'b0, lcd_byte: addr_of(n_row, n_col)};
            end
            clct_pkg::K_CLEAR: begin
                n_row     = '0;
                n_col     = '0;
                n_list[0] = '{is_data: 1'b0, lcd_byte: clct_pkg::CMD_CLEAR};
            end
            default: begin
                n_cnt = 2'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_list <= n_list;
            r_cnt  <= n_cnt;
        end
        if (adv) begin
            r_out_word <= r_list[r_pos];
            r_out_last <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_clr   <= 1'b0;
            r_job_v <= 1'b0;
            r_pos   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (adv) begin
                r_out_v <= emit;
            end
            if (load) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_clr   <= n_clr;
                r_job_v <= 1'b1;
                r_pos   <= '0;
            end else if (fin) begin
                r_job_v <= 1'b0;
            end else if (emit) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    a_pos_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_v |-> (r_pos < r_cnt))
        else $error("byte position past end of job");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_row) < ROWS) && (int'(r_col) < COLS))
        else $error("cursor outside the display");

    a_clear_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_op.kind == clct_pkg::K_CHAR) |=> !r_clr)
        else $error("pending clear survived a printed character");

endmodule

`default_nettype wire

[design/char_lcd_cursor_terminal_unit.sv]
// An accepted item is queued, loaded into the back end's byte list, then sent
// from its output register, one LCD byte per cycle while m_tready is high.
// An item gives one to three bytes. Items that produce no byte never reach the queue.
// The back end sets the rate; its output register lets the next operation load early.
// Reset (synchronous, active low) homes the cursor, drops any pending clear,
// empties the queue and the output register, and clears extended_chars.
// ============================================================================
// char_lcd_cursor_terminal_unit: HD44780 cursor terminal
// Turns a stream of characters and cursor commands into HD44780 command and
// data bytes while keeping track of the cursor position on the display.
// ============================================================================
`default_nettype none

module char_lcd_cursor_terminal_unit #(
    parameter int ROWS = 2,
    parameter int COLS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    // Slave-side stream.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata: char_code [7:0], move_dir [10:8], col_pos [16:11],
    //          row_pos [19:17], zero fill [23:20].
    input  wire logic [23:0]  s_tdata,
    // s_tuser: kind [1:0].
    input  wire logic [1:0]   s_tuser,

    // Master-side stream.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata: lcd_byte [7:0].
    output logic [7:0]        m_tdata,
    // m_tuser: is_data [0].
    output logic              m_tuser,
    output logic              m_tlast,

    // Configuration port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // The only configuration register selects whether bytes above 0x7F pass
    // to the display untouched or are folded to plain ASCII letters or the block glyph.
    logic r_ext_chars;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == clct_pkg::REG_EXT_CHARS) ? {31'b0, r_ext_chars} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_chars <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == clct_pkg::REG_EXT_CHARS) begin
            r_ext_chars <= pwdata[0];
        end
    end

    // The front end classifies each transfer combinationally. Items that
    // cause no LCD byte (ignored control bytes, off-screen positions) are
    // accepted and dropped here, so the back end only sees real work.
    clct_pkg::t_op front_op;
    logic          front_keep;

    clct_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_kind      (s_tuser),
        .i_char_code (s_tdata[7:0]),
        .i_move_dir  (s_tdata[10:8]),
        .i_col_pos   (s_tdata[16:11]),
        .i_row_pos   (s_tdata[19:17]),
        .i_ext_chars (r_ext_chars),
        .o_op        (front_op),
        .o_keep      (front_keep)
    );

    // A short queue lets the input keep flowing while the back end is still
    // sending the bytes of earlier operations.
    logic          q_not_full;
    logic          q_not_empty;
    logic          q_pop;
    clct_pkg::t_op q_head;

    assign s_tready = q_not_full;

    clct_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_tvalid && s_tready && front_keep),
        .i_push_op   (front_op),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_head      (q_head)
    );

    // The back end owns the cursor and the pending clear flag. It loads an
    // operation, works out all of its bytes at once, then sends them in
    // order through a registered output stage.
    clct_pkg::t_lcd_word out_word;

    clct_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_not_empty),
        .i_op       (q_head),
        .o_op_pop   (q_pop),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_word     (out_word),
        .o_last     (m_tlast)
    );

    assign m_tdata = out_word.lcd_byte;
    assign m_tuser = out_word.is_data;

endmodule

`default_nettype wire
